// ===== hw/rtl/double_word_by_word_divider_core_defines.svh =====
// Assertion macros for the double-word by word divider core.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef DOUBLE_WORD_BY_WORD_DIVIDER_CORE_DEFINES_SVH
`define DOUBLE_WORD_BY_WORD_DIVIDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DWBWD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwbwd: same-cycle check failed");

`define DWBWD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwbwd: next-cycle check failed");

`else

`define DWBWD_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define DWBWD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/dwbwd_pkg.sv =====
// Shared types and status codes for the double-word by word divider.
// No dependencies.
`default_nettype none

package dwbwd_pkg;

   localparam int STATUS_BITS = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                   valid;
      logic [STATUS_BITS-1:0] status;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dwbwd_precheck.sv =====
// Entry stage of the divider: masks the operands to the word width, classifies
// the request and registers it. Depends on dwbwd_pkg.
`default_nettype none

module dwbwd_precheck #(
   parameter int WORD_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       req_valid,
   input  logic [63:0]                req_dividend_high,
   input  logic [63:0]                req_dividend_low,
   input  logic [63:0]                req_divisor,
   output dwbwd_pkg::stage_ctrl_type  ctrl,
   output logic [WORD_BITS-1:0]       rem,
   output logic [WORD_BITS-1:0]       lq,
   output logic [WORD_BITS-1:0]       div
);

   logic [WORD_BITS-1:0] high_word;
   logic [WORD_BITS-1:0] low_word;
   logic [WORD_BITS-1:0] div_word;

   dwbwd_pkg::stage_ctrl_type ctrl_ff;
   dwbwd_pkg::stage_ctrl_type ctrl_in;
   logic [WORD_BITS-1:0]      rem_ff;
   logic [WORD_BITS-1:0]      lq_ff;
   logic [WORD_BITS-1:0]      div_ff;

   assign high_word = req_dividend_high[WORD_BITS-1:0];
   assign low_word  = req_dividend_low[WORD_BITS-1:0];
   assign div_word  = req_divisor[WORD_BITS-1:0];

   always_comb begin
      ctrl_in.valid = req_valid;
      if (div_word == '0) begin
         ctrl_in.status = dwbwd_pkg::STATUS_DIV_ZERO;
      end else if (high_word >= div_word) begin
         ctrl_in.status = dwbwd_pkg::STATUS_OVERFLOW;
      end else begin
         ctrl_in.status = dwbwd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (enable) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= high_word;
         lq_ff  <= low_word;
         div_ff <= div_word;
      end
   end

   assign ctrl = ctrl_ff;
   assign rem  = rem_ff;
   assign lq   = lq_ff;
   assign div  = div_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dwbwd_step.sv =====
// One restoring division step: shifts in one dividend bit, conditionally
// subtracts the divisor and registers one quotient bit. Depends on dwbwd_pkg.
`default_nettype none

module dwbwd_step #(
   parameter int WORD_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  dwbwd_pkg::stage_ctrl_type  ctrl_prev,
   input  logic [WORD_BITS-1:0]       rem_prev,
   input  logic [WORD_BITS-1:0]       lq_prev,
   input  logic [WORD_BITS-1:0]       div_prev,
   output dwbwd_pkg::stage_ctrl_type  ctrl,
   output logic [WORD_BITS-1:0]       rem,
   output logic [WORD_BITS-1:0]       lq,
   output logic [WORD_BITS-1:0]       div
);

   logic                 top_bit;
   logic [WORD_BITS-1:0] shifted;
   logic [WORD_BITS+1:0] diff;
   logic                 take;

   dwbwd_pkg::stage_ctrl_type ctrl_ff;
   logic [WORD_BITS-1:0]      rem_ff;
   logic [WORD_BITS-1:0]      rem_in;
   logic [WORD_BITS-1:0]      lq_ff;
   logic [WORD_BITS-1:0]      lq_in;
   logic [WORD_BITS-1:0]      div_ff;

   // The partial remainder stays below the divisor, so one extra bit holds the shift.
   assign top_bit = rem_prev[WORD_BITS-1];
   assign shifted = {rem_prev[WORD_BITS-2:0], lq_prev[WORD_BITS-1]};
   assign diff    = {1'b0, top_bit, shifted} - {2'b00, div_prev};
   assign take    = ~diff[WORD_BITS+1];
   assign rem_in  = take ? diff[WORD_BITS-1:0] : shifted;
   assign lq_in   = {lq_prev[WORD_BITS-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (enable) begin
         ctrl_ff <= ctrl_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         lq_ff  <= lq_in;
         div_ff <= div_prev;
      end
   end

   assign ctrl = ctrl_ff;
   assign rem  = rem_ff;
   assign lq   = lq_ff;
   assign div  = div_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/double_word_by_word_divider_core.sv =====
// Pipelined double-word by word unsigned divider; depends on dwbwd_pkg, dwbwd_precheck,
// dwbwd_step and the assertion macro header.
// A request passes through an entry stage, one stage per quotient bit and an output register
// before its response is valid. One request is taken per cycle while the pipeline advances;
// the whole pipeline holds only while an unaccepted response sits in the output register.
// Synchronous reset empties every stage; no payload register is cleared.
`default_nettype none

`include "double_word_by_word_divider_core_defines.svh"

module double_word_by_word_divider_core #(
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_dividend_high,
   input  logic [63:0] req_dividend_low,
   input  logic [63:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_quotient,
   output logic [63:0] rsp_remainder,
   output logic [1:0]  rsp_status
);

   logic advance;

   dwbwd_pkg::stage_ctrl_type ctrl_pipe [0:WORD_BITS];
   logic [WORD_BITS-1:0]      rem_pipe  [0:WORD_BITS];
   logic [WORD_BITS-1:0]      lq_pipe   [0:WORD_BITS];
   logic [WORD_BITS-1:0]      div_pipe  [0:WORD_BITS];

   logic                              rsp_valid_ff;
   logic [WORD_BITS-1:0]              quot_ff;
   logic [WORD_BITS-1:0]              quot_in;
   logic [WORD_BITS-1:0]              rem_ff;
   logic [WORD_BITS-1:0]              rem_in;
   logic [dwbwd_pkg::STATUS_BITS-1:0] status_ff;
   logic [WORD_BITS+1:0]              valid_vec;

   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;

   dwbwd_precheck #(
      .WORD_BITS(WORD_BITS)
   ) u_precheck (
      .clock             (clock),
      .reset             (reset),
      .enable            (advance),
      .req_valid         (req_valid),
      .req_dividend_high (req_dividend_high),
      .req_dividend_low  (req_dividend_low),
      .req_divisor       (req_divisor),
      .ctrl              (ctrl_pipe[0]),
      .rem               (rem_pipe[0]),
      .lq                (lq_pipe[0]),
      .div               (div_pipe[0])
   );

   for (genvar s = 0; s < WORD_BITS; s++) begin : g_step
      dwbwd_step #(
         .WORD_BITS(WORD_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .ctrl_prev (ctrl_pipe[s]),
         .rem_prev  (rem_pipe[s]),
         .lq_prev   (lq_pipe[s]),
         .div_prev  (div_pipe[s]),
         .ctrl      (ctrl_pipe[s+1]),
         .rem       (rem_pipe[s+1]),
         .lq        (lq_pipe[s+1]),
         .div       (div_pipe[s+1])
      );
   end

   // Failed requests report zero for both quotient and remainder.
   always_comb begin
      if (ctrl_pipe[WORD_BITS].status == dwbwd_pkg::STATUS_OK) begin
         quot_in = lq_pipe[WORD_BITS];
         rem_in  = rem_pipe[WORD_BITS];
      end else begin
         quot_in = '0;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctrl_pipe[WORD_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         status_ff <= ctrl_pipe[WORD_BITS].status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quotient  = 64'(quot_ff);
   assign rsp_remainder = 64'(rem_ff);
   assign rsp_status    = status_ff;

   always_comb begin
      for (int s = 0; s <= WORD_BITS; s++) begin
         valid_vec[s] = ctrl_pipe[s].valid;
      end
      valid_vec[WORD_BITS+1] = rsp_valid_ff;
   end

   `DWBWD_ASSERT_IMP(a_entry_ok_in_range, clock, reset, ctrl_pipe[0].valid && ctrl_pipe[0].status == dwbwd_pkg::STATUS_OK, rem_pipe[0] < div_pipe[0])

   `DWBWD_ASSERT_IMP(a_final_rem_below_div, clock, reset, ctrl_pipe[WORD_BITS].valid && ctrl_pipe[WORD_BITS].status == dwbwd_pkg::STATUS_OK, rem_pipe[WORD_BITS] < div_pipe[WORD_BITS])

   `DWBWD_ASSERT_IMP(a_error_zeroes_result, clock, reset, rsp_valid_ff && status_ff != dwbwd_pkg::STATUS_OK, quot_ff == '0 && rem_ff == '0)

   `DWBWD_ASSERT_NXT(a_stall_freezes_pipe, clock, reset, !advance, $stable(valid_vec))

endmodule

`default_nettype wire
